### sv/pfb_pkg.sv
// ----------------------------------------------------------------------------
// Page framebuffer package
// Operation codes, word types and sequencer states for the page framebuffer.
// ----------------------------------------------------------------------------
package pfb_pkg;

	typedef enum logic [2:0] {
		OP_CLEAR     = 3'd0,
		OP_SET_PIXEL = 3'd1,
		OP_HLINE     = 3'd2,
		OP_WRITE_COL = 3'd3,
		OP_FLUSH     = 3'd4,
		OP_XFER_DONE = 3'd5
	} op_t;

	// One command word.
	typedef struct packed {
		op_t        op;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [2:0] page_sel;
		logic [7:0] column_byte;
		logic       sent_ok;
	} req_t;

	// One flush word: eight column bytes of a page.
	typedef struct packed {
		logic [2:0]  out_page;
		logic [6:0]  column_base;
		logic [63:0] eight_columns;
		logic        last_of_page;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LINE,
		ST_FLUSH
	} state_t;

endpackage

### sv/page_framebuffer_dirty_flush.sv
// ----------------------------------------------------------------------------
// Page framebuffer with dirty tracking
// Monochrome page framebuffer held in one memory of eight-column words, with
// a dirty mark per page and a flush that streams a dirty page out.
// ----------------------------------------------------------------------------
// The pixels live in a simple dual-port synchronous memory of
// PAGE_COUNT * ceil(COLUMN_COUNT/8) words of 64 bits, each word holding eight
// column bytes of one page, so a flush reads one word per output word. After
// reset, and after every clear command, the block sweeps the memory writing
// zeros, one word a cycle, until every word is cleared; command words are
// stalled during the sweep. Set pixel and write column are a read-modify-write
// of one memory word: the read is issued as the word is accepted and the
// write-back in the next cycle, during which the command channel is stalled so
// that a following command never reads a word whose write is still pending. A
// horizontal line walks every word of its page with reads and write-backs
// overlapped: after the accepting cycle it issues one read per word, and the
// next command is taken after the final write-back. Transfer done and a flush
// of a clean page complete in the cycle they are accepted. A flush of a dirty
// page issues a memory read only while the output register is free and no
// earlier read of the flush is still landing; its length is set by how fast the
// receiver takes the words. The output register parts the two sides, so a new
// command can be accepted while the last flush word still waits to be taken.
// Bytes of columns beyond COLUMN_COUNT in the final word of a page are never
// written with anything but zero, so they always read as zero.
module page_framebuffer_dirty_flush import pfb_pkg::*; #(
	parameter int unsigned PAGE_COUNT   = 8,
	parameter int unsigned COLUMN_COUNT = 128
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int unsigned ROW_COUNT   = PAGE_COUNT * 8;
	localparam int unsigned GROUP_COUNT = (COLUMN_COUNT + 7) / 8;
	localparam int unsigned WORD_COUNT  = PAGE_COUNT * GROUP_COUNT;
	localparam int unsigned AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int unsigned PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int unsigned GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int unsigned TAIL_COLS = COLUMN_COUNT % 8;
	localparam logic [7:0] LAST_LANES =
		(TAIL_COLS == 0) ? 8'hFF : 8'((9'd1 << TAIL_COLS) - 9'd1);

	// Widens a per-byte lane mask to a per-bit mask over one memory word.
	function automatic logic [63:0] lanes_to_bits(input logic [7:0] lanes);
		logic [63:0] bits;
		bits = '0;
		for (int k = 0; k < 8; k++) begin
			bits[8*k +: 8] = {8{lanes[k]}};
		end
		return bits;
	endfunction

	localparam logic [63:0] LAST_MASK = lanes_to_bits(LAST_LANES);

	// Word address of one group of eight columns in a page.
	function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] page,
			input logic [GW-1:0] grp);
		return AW'(int'(page) * GROUP_COUNT + int'(grp));
	endfunction

	// Pixel memory.
	logic [63:0] mem [WORD_COUNT];

	state_t state_q, state_d;

	logic [AW-1:0]         clr_q, clr_d;
	logic [GW-1:0]         grp_q, grp_d;
	logic [PW-1:0]         page_q, page_d;
	logic [7:0]            row_bits_q, row_bits_d;
	logic [PAGE_COUNT-1:0] dirty_q, dirty_d;

	// Stage 1: the memory read issued in the previous cycle has landed.
	logic          s1_valid_q, s1_valid_d;
	logic          s1_flush_q, s1_flush_d;
	logic          s1_last_q, s1_last_d;
	logic [GW-1:0] s1_grp_q, s1_grp_d;
	logic [AW-1:0] s1_addr_q, s1_addr_d;
	logic [63:0]   s1_set_q, s1_set_d;
	logic [63:0]   s1_clr_q, s1_clr_d;
	logic [63:0]   rd_word_s1;

	logic          rsp_valid_q, rsp_valid_d;
	rsp_t          rsp_q, rsp_d;

	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [63:0]   wr_data;

	logic          acc;
	logic          x_ok, y_ok, p_ok;
	logic [PW-1:0] y_page, sel_page;
	logic [GW-1:0] x_group;
	logic [2:0]    lane, row_bit;
	logic          grp_last;

	assign req_stall = (state_q != ST_IDLE) || s1_valid_q;
	assign acc       = req_valid && !req_stall;

	assign x_ok     = {1'b0, req.pos_x} < 9'(COLUMN_COUNT);
	assign y_ok     = {1'b0, req.pos_y} < 9'(ROW_COUNT);
	assign p_ok     = {2'b00, req.page_sel} < 5'(PAGE_COUNT);
	assign y_page   = PW'(req.pos_y >> 3);
	assign sel_page = PW'(req.page_sel);
	assign x_group  = GW'(req.pos_x >> 3);
	assign lane     = req.pos_x[2:0];
	assign row_bit  = req.pos_y[2:0];
	assign grp_last = (grp_q == GW'(GROUP_COUNT - 1));

	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		grp_d       = grp_q;
		page_d      = page_q;
		row_bits_d  = row_bits_q;
		dirty_d     = dirty_q;
		s1_valid_d  = 1'b0;
		s1_flush_d  = 1'b0;
		s1_last_d   = 1'b0;
		s1_grp_d    = grp_q;
		s1_addr_d   = s1_addr_q;
		s1_set_d    = '0;
		s1_clr_d    = '0;
		rd_en       = 1'b0;
		rd_addr     = '0;
		wr_en       = s1_valid_q && !s1_flush_q;
		wr_addr     = s1_addr_q;
		wr_data     = (rd_word_s1 & ~s1_clr_q) | s1_set_q;
		rsp_valid_d = rsp_valid_q;
		rsp_d       = rsp_q;

		// Output register: a landed flush read fills it, a taken word empties it.
		if (s1_valid_q && s1_flush_q) begin
			rsp_valid_d             = 1'b1;
			rsp_d.out_page          = 3'(page_q);
			rsp_d.column_base       = 7'({s1_grp_q, 3'b000});
			rsp_d.eight_columns     = rd_word_s1;
			rsp_d.last_of_page      = s1_last_q;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_d = 1'b0;
		end

		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				if (clr_q == AW'(WORD_COUNT - 1)) begin
					clr_d   = '0;
					state_d = ST_IDLE;
				end else begin
					clr_d = AW'(clr_q + 1'b1);
				end
			end
			ST_IDLE: begin
				if (acc) begin
					unique case (req.op)
						OP_CLEAR: begin
							dirty_d = '1;
							clr_d   = '0;
							state_d = ST_CLEAR;
						end
						OP_SET_PIXEL: begin
							if (x_ok && y_ok) begin
								rd_en           = 1'b1;
								rd_addr         = addr_of(y_page, x_group);
								s1_valid_d      = 1'b1;
								s1_addr_d       = rd_addr;
								s1_set_d        = 64'd1 << {lane, row_bit};
								dirty_d[y_page] = 1'b1;
							end
						end
						OP_HLINE: begin
							if (y_ok) begin
								page_d          = y_page;
								row_bits_d      = 8'd1 << row_bit;
								grp_d           = '0;
								dirty_d[y_page] = 1'b1;
								state_d         = ST_LINE;
							end
						end
						OP_WRITE_COL: begin
							if (x_ok && p_ok) begin
								rd_en             = 1'b1;
								rd_addr           = addr_of(sel_page, x_group);
								s1_valid_d        = 1'b1;
								s1_addr_d         = rd_addr;
								s1_set_d          = 64'(req.column_byte) << {lane, 3'b000};
								s1_clr_d          = 64'hFF << {lane, 3'b000};
								dirty_d[sel_page] = 1'b1;
							end
						end
						OP_FLUSH: begin
							if (p_ok && dirty_q[sel_page]) begin
								page_d  = sel_page;
								grp_d   = '0;
								state_d = ST_FLUSH;
							end
						end
						OP_XFER_DONE: begin
							if (p_ok && req.sent_ok) begin
								dirty_d[sel_page] = 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_LINE: begin
				// Read of this group overlaps the write-back of the previous one.
				rd_en      = 1'b1;
				rd_addr    = addr_of(page_q, grp_q);
				s1_valid_d = 1'b1;
				s1_addr_d  = rd_addr;
				s1_set_d   = {8{row_bits_q}} & (grp_last ? LAST_MASK : '1);
				if (grp_last) begin
					grp_d   = '0;
					state_d = ST_IDLE;
				end else begin
					grp_d = GW'(grp_q + 1'b1);
				end
			end
			ST_FLUSH: begin
				// Issue a read only when the output register is sure to be free
				// as the data lands.
				if (!s1_valid_q && (!rsp_valid_q || !rsp_stall)) begin
					rd_en      = 1'b1;
					rd_addr    = addr_of(page_q, grp_q);
					s1_valid_d = 1'b1;
					s1_flush_d = 1'b1;
					s1_last_d  = grp_last;
					s1_addr_d  = rd_addr;
					if (grp_last) begin
						grp_d   = '0;
						state_d = ST_IDLE;
					end else begin
						grp_d = GW'(grp_q + 1'b1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			grp_q       <= '0;
			dirty_q     <= '1;
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			clr_q       <= clr_d;
			grp_q       <= grp_d;
			dirty_q     <= dirty_d;
			s1_valid_q  <= s1_valid_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		page_q     <= page_d;
		row_bits_q <= row_bits_d;
		s1_flush_q <= s1_flush_d;
		s1_last_q  <= s1_last_d;
		s1_grp_q   <= s1_grp_d;
		s1_addr_q  <= s1_addr_d;
		s1_set_q   <= s1_set_d;
		s1_clr_q   <= s1_clr_d;
		rsp_q      <= rsp_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_s1 <= mem[rd_addr];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A write-back never collides with a read of the same word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("read and write of the same word in one cycle");

	// A landing flush read never overwrites a word still waiting at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && s1_flush_q) |-> (!rsp_valid_q || !rsp_stall))
		else $error("flush word overwrote a pending output word");

	// Only a dirty page is ever streamed out.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> dirty_q[page_q])
		else $error("flush in progress on a clean page");

	// The clearing sweep never runs with a read-modify-write in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s1_valid_q)
		else $error("clearing sweep overlaps a pending write-back");

endmodule

### tb/page_framebuffer_dirty_flush_tb.sv
// ----------------------------------------------------------------------------
// Page framebuffer with dirty tracking: testbench
// Drives command words into the framebuffer, keeps a shadow copy of the
// pixels and the per-page dirty marks, and checks every flush word against it.
// ----------------------------------------------------------------------------
module page_framebuffer_dirty_flush_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pfb_pkg::*;

	localparam int PAGES        = 8;
	localparam int COLUMNS      = 128;
	localparam int ROWS         = PAGES * 8;
	localparam int GROUPS       = (COLUMNS + 7) / 8;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 64;
	localparam int PHASE_ITEMS  = 75;

	// Opcodes that the block must treat as no operation.
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	// How the flush words of a directed row are worked out.
	typedef enum logic [1:0] {
		OUT_FROM_MODEL,
		OUT_BLANK_PAGE,
		OUT_NONE
	} outcome_t;

	typedef struct {
		req_t     cmd;
		outcome_t outcome;
	} plan_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Shadow of the framebuffer contents and of the dirty marks.
	logic [7:0] pixel_bytes [PAGES][COLUMNS];
	bit         page_is_dirty [PAGES];

	rsp_t      flush_words_due[$];
	rsp_t      flush_words_new[$];
	plan_row_t directed_plan[$];

	int mismatches     = 0;
	int quiet_cycles   = 0;
	int send_gap_pct   = 0;
	int recv_stall_pct = 0;

	page_framebuffer_dirty_flush #(
		.PAGE_COUNT  (PAGES),
		.COLUMN_COUNT(COLUMNS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic req_t compose(logic [2:0] code, int x, int y, int pg, int cb, bit ok);
		req_t c;
		c.op          = op_t'(code);
		c.pos_x       = 8'(x);
		c.pos_y       = 8'(y);
		c.page_sel    = 3'(pg);
		c.column_byte = 8'(cb);
		c.sent_ok     = ok;
		return c;
	endfunction

	// Applies one command to the shadow state. Any flush words it produces are
	// left in flush_words_new. Returns 0 when the block should ignore the word.
	function automatic bit apply_command(req_t c);
		int x;
		int y;
		int pg;
		int col;
		bit effective;
		logic [63:0] group_bytes;
		x  = int'(c.pos_x);
		y  = int'(c.pos_y);
		pg = int'(c.page_sel);
		effective = 1'b0;
		flush_words_new.delete();
		case (c.op)
			OP_CLEAR: begin
				foreach (pixel_bytes[p, k]) pixel_bytes[p][k] = '0;
				foreach (page_is_dirty[p]) page_is_dirty[p] = 1'b1;
				effective = 1'b1;
			end
			OP_SET_PIXEL: begin
				if (x < COLUMNS && y < ROWS) begin
					pixel_bytes[y / 8][x][y % 8] = 1'b1;
					page_is_dirty[y / 8] = 1'b1;
					effective = 1'b1;
				end
			end
			OP_HLINE: begin
				if (y < ROWS) begin
					for (int k = 0; k < COLUMNS; k++) pixel_bytes[y / 8][k][y % 8] = 1'b1;
					page_is_dirty[y / 8] = 1'b1;
					effective = 1'b1;
				end
			end
			OP_WRITE_COL: begin
				if (x < COLUMNS && pg < PAGES) begin
					pixel_bytes[pg][x] = c.column_byte;
					page_is_dirty[pg] = 1'b1;
					effective = 1'b1;
				end
			end
			OP_FLUSH: begin
				if (pg < PAGES) begin
					effective = 1'b1;
					if (page_is_dirty[pg]) begin
						for (int g = 0; g < GROUPS; g++) begin
							group_bytes = '0;
							for (int k = 0; k < 8; k++) begin
								col = g * 8 + k;
								if (col < COLUMNS) group_bytes[8 * k +: 8] = pixel_bytes[pg][col];
							end
							flush_words_new.push_back('{3'(pg), 7'(g * 8), group_bytes,
								g == GROUPS - 1});
						end
					end
				end
			end
			OP_XFER_DONE: begin
				if (pg < PAGES && c.sent_ok) begin
					page_is_dirty[pg] = 1'b0;
					effective = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return effective;
	endfunction

	// Offers one word after a random gap, waits for it to be taken, and then
	// records the flush words it is due to produce. Prediction happens in the
	// cycle of acceptance, so the shadow state follows the block's order.
	task automatic issue_command(input req_t c, input outcome_t outcome, output bit effective);
		while ($urandom_range(99) < send_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= c;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall !== 1'b0);
		effective = apply_command(c);
		case (outcome)
			OUT_FROM_MODEL: begin
				foreach (flush_words_new[i]) flush_words_due.push_back(flush_words_new[i]);
			end
			OUT_BLANK_PAGE: begin
				for (int g = 0; g < GROUPS; g++)
					flush_words_due.push_back('{c.page_sel, 7'(g * 8), 64'd0, g == GROUPS - 1});
			end
			default: begin
			end
		endcase
	endtask

	task automatic add_row(input logic [2:0] code, input int x, input int y, input int pg,
			input int cb, input bit ok, input outcome_t outcome);
		directed_plan.push_back('{compose(code, x, y, pg, cb, ok), outcome});
	endtask

	// A realistic page session: a few drawing commands aimed at one page, a
	// flush, a transfer report that usually succeeds, and sometimes a second
	// flush to see whether the dirty mark really cleared. Fields that the
	// operation does not use are still randomised.
	task automatic run_page_session(inout int credited);
		int pg;
		bit effective;
		pg = $urandom_range(PAGES - 1);
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(2))
				0: issue_command(compose(OP_SET_PIXEL, $urandom_range(COLUMNS - 1),
					pg * 8 + $urandom_range(7), $urandom_range(7), $urandom_range(255),
					$urandom_range(1)), OUT_FROM_MODEL, effective);
				1: issue_command(compose(OP_HLINE, $urandom_range(255),
					pg * 8 + $urandom_range(7), $urandom_range(7), $urandom_range(255),
					$urandom_range(1)), OUT_FROM_MODEL, effective);
				default: issue_command(compose(OP_WRITE_COL, $urandom_range(COLUMNS - 1),
					$urandom_range(255), pg, $urandom_range(255), $urandom_range(1)),
					OUT_FROM_MODEL, effective);
			endcase
			credited += int'(effective);
		end
		issue_command(compose(OP_FLUSH, $urandom_range(255), $urandom_range(255), pg,
			$urandom_range(255), $urandom_range(1)), OUT_FROM_MODEL, effective);
		credited += int'(effective);
		issue_command(compose(OP_XFER_DONE, $urandom_range(255), $urandom_range(255), pg,
			$urandom_range(255), $urandom_range(99) < 75), OUT_FROM_MODEL, effective);
		credited += int'(effective);
		if ($urandom_range(1) == 1) begin
			issue_command(compose(OP_FLUSH, $urandom_range(255), $urandom_range(255), pg,
				$urandom_range(255), $urandom_range(1)), OUT_FROM_MODEL, effective);
			credited += int'(effective);
		end
	endtask

	// The receiver stalls at random at the rate of the current phase.
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Every flush word taken is compared with the oldest one still due.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (flush_words_due.size() == 0) begin
				report_mismatch($sformatf("flush word page %0d base %0d with none due",
					rsp.out_page, rsp.column_base));
			end else begin
				want = flush_words_due.pop_front();
				if (rsp.out_page !== want.out_page)
					report_mismatch($sformatf("out_page %0d, due %0d",
						rsp.out_page, want.out_page));
				if (rsp.column_base !== want.column_base)
					report_mismatch($sformatf("column_base %0d, due %0d",
						rsp.column_base, want.column_base));
				if (rsp.eight_columns !== want.eight_columns)
					report_mismatch($sformatf("eight_columns %h, due %h at page %0d base %0d",
						rsp.eight_columns, want.eight_columns, want.out_page,
						want.column_base));
				if (rsp.last_of_page !== want.last_of_page)
					report_mismatch($sformatf("last_of_page %0d, due %0d at base %0d",
						rsp.last_of_page, want.last_of_page, want.column_base));
			end
		end
	end

	// The watchdog ends the run when neither channel has moved a word for
	// far longer than the clearing sweep or the longest random stall.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int credited;
		bit effective;
		logic [2:0] code;

		// After reset the screen is blank and every page is pending.
		foreach (pixel_bytes[p, k]) pixel_bytes[p][k] = '0;
		foreach (page_is_dirty[p]) page_is_dirty[p] = 1'b1;

		// Directed part. Rows with a typed outcome can be read straight off the
		// behaviour: a page flushed after reset or a clear is blank, and
		// ignored or clean-page words produce nothing.
		add_row(OP_FLUSH,     0,   0,   0, 0,   0, OUT_BLANK_PAGE);
		add_row(OP_FLUSH,     0,   0,   7, 0,   0, OUT_BLANK_PAGE);
		add_row(OP_XFER_DONE, 0,   0,   0, 0,   0, OUT_NONE);
		add_row(OP_FLUSH,     0,   0,   0, 0,   0, OUT_BLANK_PAGE);
		add_row(OP_XFER_DONE, 0,   0,   0, 0,   1, OUT_NONE);
		add_row(OP_FLUSH,     0,   0,   0, 0,   0, OUT_NONE);
		add_row(OP_SET_PIXEL, 0,   0,   0, 0,   0, OUT_NONE);
		add_row(OP_SET_PIXEL, 127, 63,  0, 0,   0, OUT_NONE);
		add_row(OP_SET_PIXEL, 128, 5,   0, 0,   0, OUT_NONE);
		add_row(OP_SET_PIXEL, 5,   64,  0, 0,   0, OUT_NONE);
		add_row(OP_SET_PIXEL, 255, 255, 7, 255, 1, OUT_NONE);
		add_row(OP_FLUSH,     0,   0,   0, 0,   0, OUT_FROM_MODEL);
		add_row(OP_FLUSH,     0,   0,   7, 0,   0, OUT_FROM_MODEL);
		add_row(OP_HLINE,     0,   9,   0, 0,   0, OUT_NONE);
		add_row(OP_HLINE,     0,   200, 0, 0,   0, OUT_NONE);
		add_row(OP_WRITE_COL, 0,   0,   3, 255, 0, OUT_NONE);
		add_row(OP_WRITE_COL, 127, 0,   3, 165, 0, OUT_NONE);
		add_row(OP_WRITE_COL, 200, 0,   3, 90,  0, OUT_NONE);
		add_row(OP_FLUSH,     0,   0,   3, 0,   0, OUT_FROM_MODEL);
		add_row(OP_XFER_DONE, 0,   0,   3, 0,   1, OUT_NONE);
		add_row(OP_FLUSH,     0,   0,   1, 0,   0, OUT_FROM_MODEL);
		add_row(OP_SPARE_6,   255, 255, 0, 255, 1, OUT_NONE);
		add_row(OP_SPARE_7,   255, 255, 4, 255, 1, OUT_NONE);
		add_row(OP_CLEAR,     0,   0,   0, 0,   0, OUT_NONE);
		add_row(OP_FLUSH,     0,   0,   3, 0,   0, OUT_BLANK_PAGE);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_plan[i])
			issue_command(directed_plan[i].cmd, directed_plan[i].outcome, effective);

		// Random part in four phases of idling: none, a mostly idle sender,
		// a mostly stalling receiver, and light idling on both sides. Most of
		// it is page sessions; the rest is random words, with clears kept
		// rare because each one costs a full memory sweep.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_gap_pct = 76; recv_stall_pct = 0;  end
				2: begin send_gap_pct = 0;  recv_stall_pct = 76; end
				default: begin send_gap_pct = 9; recv_stall_pct = 9; end
			endcase
			credited = 0;
			while (credited < PHASE_ITEMS) begin
				if ($urandom_range(99) < 70) begin
					run_page_session(credited);
				end else begin
					code = 3'($urandom_range(7));
					if (code == OP_CLEAR && $urandom_range(9) != 0) code = OP_FLUSH;
					issue_command(compose(code, $urandom_range(255), $urandom_range(255),
						$urandom_range(7), $urandom_range(255), $urandom_range(1)),
						OUT_FROM_MODEL, effective);
					credited += int'(effective);
				end
			end
		end
		req_valid <= 1'b0;

		// Let every due flush word arrive, then give the block time to show
		// any word it should not have produced.
		while (flush_words_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
